// ----- design/smf_pkg.sv -----
`timescale 1ns / 1ps

package smf_pkg;

  // Default window length and sample width
  localparam int WINDOW_DEF      = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  // Flags that one cell hands to its neighbors in the sorted row
  typedef struct packed {
    logic gt;  // the cell's value is greater than the incoming sample
    logic rb;  // the oldest entry sits at this cell or below it
  } smf_link_t;

endpackage

// ----- design/smf_if.sv -----
`timescale 1ns / 1ps

// Sample stream
interface smf_sample_if #(
  parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Median stream
interface smf_median_if #(
  parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ----- design/smf_cell.sv -----
`timescale 1ns / 1ps

module smf_cell #(
  parameter int WINDOW      = smf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX       = 0,
  parameter int AW          = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] lo_val_i,
  input  logic [AW-1:0]                 lo_age_i,
  input  smf_pkg::smf_link_t            lo_link_i,
  input  logic signed [SAMPLE_BITS-1:0] hi_val_i,
  input  logic [AW-1:0]                 hi_age_i,
  input  smf_pkg::smf_link_t            hi_link_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic [AW-1:0]                 age_o,
  output smf_pkg::smf_link_t            link_o
);
  import smf_pkg::*;

  localparam logic [AW-1:0] OLD_AGE   = AW'(WINDOW - 1);
  localparam logic [AW-1:0] RESET_AGE = AW'(INDEX);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]                 age_q, age_d;
  logic                          gt;
  logic                          rb;
  logic signed [SAMPLE_BITS-1:0] c_lo_val, c_hi_val;
  logic [AW-1:0]                 c_lo_age, c_hi_age;
  logic                          c_lo_gt, c_hi_gt;

  // Compare against the incoming sample, track where the oldest entry sits
  assign gt     = val_q > sample_i;
  assign rb     = lo_link_i.rb | (age_q == OLD_AGE);
  assign link_o = '{gt: gt, rb: rb};
  assign val_o  = val_q;
  assign age_o  = age_q;

  // Close the gap left by the oldest entry: candidates from below, this slot and above
  always_comb begin
    if (lo_link_i.rb) begin
      c_lo_val = val_q;
      c_lo_age = age_q;
      c_lo_gt  = gt;
    end else begin
      c_lo_val = lo_val_i;
      c_lo_age = lo_age_i;
      c_lo_gt  = lo_link_i.gt;
    end
    if (rb) begin
      c_hi_val = hi_val_i;
      c_hi_age = hi_age_i;
      c_hi_gt  = hi_link_i.gt;
    end else begin
      c_hi_val = val_q;
      c_hi_age = age_q;
      c_hi_gt  = gt;
    end
  end

  // Insert the new sample in order; every kept entry ages by one
  always_comb begin
    if (c_lo_gt) begin
      val_d = c_lo_val;
      age_d = c_lo_age + AW'(1);
    end else if (c_hi_gt) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = c_hi_val;
      age_d = c_hi_age + AW'(1);
    end
  end

  // Hold the cell contents until a transaction arrives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= RESET_AGE;
    end else if (shift_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule

// ----- design/sliding_median_filter.sv -----
`timescale 1ns / 1ps

// Sliding-window median filter. Each sample replaces the oldest of the last
// WINDOW samples (zero after reset) and yields one median of the whole window;
// for an even WINDOW the two middle values are averaged, truncating toward
// zero. The window is kept sorted in a row of WINDOW cells, each holding one
// value and its age; on every sample each cell takes its own value or a
// neighbor's, dropping the oldest and inserting the new one in the same
// cycle. The filter accepts one sample per clock unless stalled; the cell
// row updates on the accepting edge and the sample turns pending, and the
// median of the middle cells is captured into the output register when that
// register can load. Output back-pressure stalls the input only once one
// result waits and another is pending.
module sliding_median_filter #(
  parameter int WINDOW      = smf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  smf_sample_if.sink   sample_i,
  smf_median_if.source median_o
);
  import smf_pkg::*;

  localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID = WINDOW / 2;

  logic signed [SAMPLE_BITS-1:0] cell_val  [WINDOW];
  logic [AW-1:0]                 cell_age  [WINDOW];
  smf_link_t                     cell_link [WINDOW];

  logic                          accept;
  logic                          out_load;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic signed [SAMPLE_BITS-1:0] median_d;

  assign out_load       = !out_valid_q || median_o.ready;
  assign sample_i.ready = !pend_q || out_load;
  assign accept         = sample_i.valid && sample_i.ready;

  // Sorted row of cells
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic [AW-1:0]                 lo_age, hi_age;
    smf_link_t                     lo_link, hi_link;

    if (i == 0) begin : g_lo_edge
      assign lo_val  = '0;
      assign lo_age  = '0;
      assign lo_link = '{gt: 1'b0, rb: 1'b0};
    end else begin : g_lo_cell
      assign lo_val  = cell_val[i-1];
      assign lo_age  = cell_age[i-1];
      assign lo_link = cell_link[i-1];
    end

    if (i == WINDOW - 1) begin : g_hi_edge
      assign hi_val  = '0;
      assign hi_age  = '0;
      assign hi_link = '{gt: 1'b1, rb: 1'b1};
    end else begin : g_hi_cell
      assign hi_val  = cell_val[i+1];
      assign hi_age  = cell_age[i+1];
      assign hi_link = cell_link[i+1];
    end

    smf_cell #(
      .WINDOW     (WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .INDEX      (i),
      .AW         (AW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (sample_i.sample),
      .lo_val_i (lo_val),
      .lo_age_i (lo_age),
      .lo_link_i(lo_link),
      .hi_val_i (hi_val),
      .hi_age_i (hi_age),
      .hi_link_i(hi_link),
      .val_o    (cell_val[i]),
      .age_o    (cell_age[i]),
      .link_o   (cell_link[i])
    );
  end

  // Read the middle of the sorted row
  if ((WINDOW % 2) == 0) begin : g_even
    logic signed [SAMPLE_BITS:0] mid_sum;
    logic signed [SAMPLE_BITS:0] mid_adj;
    // Bias negative sums by one so the halving truncates toward zero
    assign mid_sum  = {cell_val[MID-1][SAMPLE_BITS-1], cell_val[MID-1]}
                    + {cell_val[MID][SAMPLE_BITS-1], cell_val[MID]};
    assign mid_adj  = mid_sum + {{SAMPLE_BITS{1'b0}}, mid_sum[SAMPLE_BITS]};
    assign median_d = mid_adj[SAMPLE_BITS:1];
  end else begin : g_odd
    assign median_d = cell_val[MID];
  end

  // Advance the pending flag and the output register
  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = pend_q;
      pend_d      = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the median of the row as it stands after the pending sample
  always_ff @(posedge clk_i) begin
    if (out_load && pend_q) begin
      median_q <= median_d;
    end
  end

  assign median_o.valid  = out_valid_q;
  assign median_o.median = median_q;

endmodule

// ----- design/smf_checker.sv -----
`timescale 1ns / 1ps

module smf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("median valid dropped while stalled");

  // No result appears without an earlier sample transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && !out_valid_i ##1 !out_valid_i |=> !out_valid_i)
    else $error("median produced without a sample");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output is empty");

  // A draining output never blocks the input
  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

endmodule

bind sliding_median_filter smf_checker u_smf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_i.valid),
  .in_ready_i (sample_i.ready),
  .out_valid_i(median_o.valid),
  .out_ready_i(median_o.ready)
);
